>>> sv/cma_pkg.sv
// Cluster map allocator: shared constants.
// Field widths, request kinds, status codes, size classes, marker bytes, heads and default sizes.
// No dependencies.
package cma_pkg;

	// Default sizes
	localparam int CMA_NUM_CLUSTERS  = 1024;
	localparam int CMA_CLUSTER_BYTES = 16384;
	localparam int BIG_LIMIT         = 5 * 1024 * 1024;

	// Stream widths
	localparam int S_DATA_W = 64;
	localparam int S_USER_W = 1;
	localparam int M_DATA_W = 48;
	localparam int M_USER_W = 3;
	localparam int ADDR_W   = 32;
	localparam int FREE_W   = 10;
	localparam int STATUS_W = 3;

	// Request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 3'd4;

	// Allocation size classes
	localparam logic [1:0] KIND_ONE  = 2'd0;
	localparam logic [1:0] KIND_FOUR = 2'd1;
	localparam logic [1:0] KIND_BIG  = 2'd2;

	// Map marker bytes
	localparam logic [7:0] MARK_FREE   = 8'h00;
	localparam logic [7:0] MARK_SINGLE = 8'hAA;
	localparam logic [7:0] MARK_FILL   = 8'hFF;
	localparam logic [7:0] MARK_BB     = 8'hBB;
	localparam logic [7:0] MARK_CC     = 8'hCC;
	localparam logic [7:0] MARK_FE     = 8'hFE;
	localparam logic [7:0] MARK_DC     = 8'hDC;
	localparam logic [7:0] MARK_BA     = 8'hBA;
	localparam logic [7:0] MARK_B8     = 8'hB8;

	// Four-byte heads as read from the map, first entry in the low byte
	localparam logic [31:0] HEAD_FOUR = 32'hB8BADCFE;
	localparam logic [31:0] HEAD_BIG  = 32'hFFFFCCBB;

endpackage

>>> sv/cluster_map_allocator_core.sv
// Cluster map allocator: top level with map memory, index split and sequencer.
// Depends on cma_pkg.
//
// One byte per cluster is kept in an internal memory. After reset the block
// sweeps the map, one entry per cycle, and only then takes its first
// request (configuration writes are taken at any time).
// CLUSTER_BYTES must be a power of two: byte counts and offsets are split
// into cluster index and remainder by a shift and a mask.
// A request is taken only while the sequencer is idle, and each produces one
// result. An allocation reads the map one entry at a time from entry 1
// until a run fits (else it reports no space), then writes one entry per
// cycle; sizes above four clusters, up to BIG_LIMIT, are first split into a
// cluster count. The largest block takes 321 entries. A free splits the
// address, reads the block head (one entry for a single block, else four),
// decodes it and clears the block's entries; a large block is cleared entry
// by entry up to its end mark, or to the end of the map if it has none.
// The result sits in an output register, so the next request can start while
// it waits to be taken.
module cluster_map_allocator_core #(
	parameter int NUM_CLUSTERS  = cma_pkg::CMA_NUM_CLUSTERS,
	parameter int CLUSTER_BYTES = cma_pkg::CMA_CLUSTER_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cma_pkg::S_DATA_W-1:0]  s_tdata,  // alloc_size[31:0], free_address[63:32]
	input  logic [cma_pkg::S_USER_W-1:0]  s_tuser,  // req_type[0]
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cma_pkg::M_DATA_W-1:0]  m_tdata,  // block_address[31:0], free_entries[41:32], zero
	output logic [cma_pkg::M_USER_W-1:0]  m_tuser,  // status[2:0]
	// base address register
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cma_pkg::ADDR_W-1:0]    cfg_data
);
	import cma_pkg::*;

	localparam int IDX_W  = $clog2(NUM_CLUSTERS);
	localparam int NW     = IDX_W + 1;
	localparam int CNT_W  = $clog2(NUM_CLUSTERS + 1);
	localparam int RW     = $clog2(CLUSTER_BYTES);
	localparam int CB_W   = $clog2(CLUSTER_BYTES + 1);
	localparam int PROD_W = IDX_W + CB_W;

	localparam logic [ADDR_W-1:0] CB32     = ADDR_W'(CLUSTER_BYTES);
	localparam logic [ADDR_W-1:0] FOUR_CB  = ADDR_W'(4 * CLUSTER_BYTES);
	localparam logic [ADDR_W-1:0] BIG32    = ADDR_W'(BIG_LIMIT);
	localparam logic [ADDR_W-1:0] NUM32    = ADDR_W'(NUM_CLUSTERS);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_CLUSTERS - 1);
	localparam logic [NW-1:0]     NUM_NW   = NW'(NUM_CLUSTERS);

	// Sequencer states
	localparam logic [3:0] ST_CLR      = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_SPLIT    = 4'd2;
	localparam logic [3:0] ST_SCAN_RD  = 4'd4;
	localparam logic [3:0] ST_SCAN_CHK = 4'd5;
	localparam logic [3:0] ST_MARK     = 4'd6;
	localparam logic [3:0] ST_F_RD     = 4'd7;
	localparam logic [3:0] ST_F_CHK    = 4'd8;
	localparam logic [3:0] ST_F_DEC    = 4'd9;
	localparam logic [3:0] ST_CLR4     = 4'd10;
	localparam logic [3:0] ST_BIG_RD   = 4'd11;
	localparam logic [3:0] ST_BIG_CHK  = 4'd12;
	localparam logic [3:0] ST_BIG_NXT  = 4'd13;
	localparam logic [3:0] ST_BIG_END  = 4'd14;
	localparam logic [3:0] ST_OUT      = 4'd15;

	logic [3:0]          state_q;
	logic [ADDR_W-1:0]   base_q;
	logic                op_free_q;
	logic [1:0]          kind_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   split_q;
	logic [NW-1:0]       need_q;
	logic [NW-1:0]       run_q;
	logic [IDX_W-1:0]    cur_q;
	logic [IDX_W-1:0]    start_q;
	logic [IDX_W-1:0]    k_q;
	logic [3:0][7:0]     head_q;
	logic [CNT_W-1:0]    free_cnt_q;
	logic [PROD_W-1:0]   prod_q;

	logic                m_tvalid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [FREE_W-1:0]   out_free_q;

	// Map memory
	logic [7:0]          map_mem [NUM_CLUSTERS];
	logic [7:0]          rd_data_q;
	logic                mem_we;
	logic                mem_re;
	logic [IDX_W-1:0]    mem_waddr;
	logic [IDX_W-1:0]    mem_raddr;
	logic [7:0]          mem_wdata;

	logic [ADDR_W-1:0]   req_size;
	logic [ADDR_W-1:0]   req_faddr;
	logic                accept;
	logic                out_load;
	logic [ADDR_W-1:0]   split_idx;
	logic [RW-1:0]       split_rem;
	logic [IDX_W-1:0]    blk_off_idx;
	logic [IDX_W-1:0]    scan_start;
	logic [NW-1:0]       k_nw;
	logic                cc_pair;
	logic                head_fits;
	logic [7:0]          mark_byte;

	assign req_size  = s_tdata[ADDR_W-1:0];
	assign req_faddr = s_tdata[2*ADDR_W-1:ADDR_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(M_DATA_W - ADDR_W - FREE_W){1'b0}}, out_free_q, out_addr_q};

	// Cluster index and remainder of a byte count or offset
	assign split_idx = split_q >> RW;
	assign split_rem = split_q[RW-1:0];

	// Index helpers
	assign blk_off_idx = start_q + k_q;
	assign k_nw        = NW'(k_q);
	assign scan_start  = IDX_W'(NW'(cur_q) + NW'(1) - need_q);
	assign cc_pair     = (rd_data_q == MARK_CC) && (cur_q != LAST_IDX);
	assign head_fits   = (NW'(start_q) + NW'(4)) <= NUM_NW;

	// Marker for the entry being written by an allocation
	always_comb begin
		mark_byte = MARK_FILL;
		unique case (kind_q)
			KIND_ONE: mark_byte = MARK_SINGLE;
			KIND_FOUR: begin
				unique case (k_q[1:0])
					2'd0: mark_byte = MARK_FE;
					2'd1: mark_byte = MARK_DC;
					2'd2: mark_byte = MARK_BA;
					default: mark_byte = MARK_B8;
				endcase
			end
			default: begin
				priority if (k_nw + NW'(1) == need_q) mark_byte = MARK_BB;
				else if (k_nw + NW'(2) == need_q) mark_byte = MARK_CC;
				else if (k_q == '0) mark_byte = MARK_BB;
				else if (k_q == IDX_W'(1)) mark_byte = MARK_CC;
				else mark_byte = MARK_FILL;
			end
		endcase
	end

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = blk_off_idx;
		mem_wdata = MARK_FREE;
		mem_re    = 1'b0;
		mem_raddr = cur_q;
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = (cur_q == '0) ? MARK_FILL : MARK_FREE;
			end
			ST_SCAN_RD: mem_re = 1'b1;
			ST_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = mark_byte;
			end
			ST_F_RD: begin
				mem_re    = 1'b1;
				mem_raddr = blk_off_idx;
			end
			ST_F_CHK: mem_we = (k_q == '0) && (rd_data_q == MARK_SINGLE);
			ST_CLR4: mem_we = 1'b1;
			ST_BIG_RD: mem_re = 1'b1;
			ST_BIG_CHK: begin
				if (cc_pair) begin
					mem_re    = 1'b1;
					mem_raddr = cur_q + IDX_W'(1);
				end else begin
					mem_we    = 1'b1;
					mem_waddr = cur_q;
				end
			end
			ST_BIG_NXT, ST_BIG_END: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) map_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= map_mem[mem_raddr];
	end

	// Base address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			op_free_q    <= REQ_ALLOC;
			kind_q       <= KIND_ONE;
			res_status_q <= STATUS_OK;
			split_q      <= '0;
			need_q       <= '0;
			run_q        <= '0;
			cur_q        <= '0;
			start_q      <= '0;
			k_q          <= '0;
			head_q       <= '0;
			free_cnt_q   <= CNT_W'(NUM_CLUSTERS - 1);
			prod_q       <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					if (cur_q == LAST_IDX) begin
						cur_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cur_q <= cur_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_free_q <= s_tuser[0];
						cur_q     <= IDX_W'(1);
						run_q     <= '0;
						if (s_tuser[0] == REQ_FREE) begin
							split_q <= req_faddr - base_q;
							state_q <= ST_SPLIT;
						end else if (req_size <= CB32) begin
							kind_q  <= KIND_ONE;
							need_q  <= NW'(1);
							state_q <= ST_SCAN_RD;
						end else if (req_size <= FOUR_CB) begin
							kind_q  <= KIND_FOUR;
							need_q  <= NW'(4);
							state_q <= ST_SCAN_RD;
						end else if (req_size <= BIG32) begin
							kind_q  <= KIND_BIG;
							split_q <= req_size;
							state_q <= ST_SPLIT;
						end else begin
							res_status_q <= STATUS_TOO_LARGE;
							state_q      <= ST_OUT;
						end
					end
				end
				ST_SPLIT: begin
					if (op_free_q == REQ_FREE) begin
						if (split_rem == '0 && split_idx < NUM32) begin
							start_q <= split_idx[IDX_W-1:0];
							k_q     <= '0;
							state_q <= ST_F_RD;
						end else begin
							res_status_q <= STATUS_IGNORED;
							state_q      <= ST_OUT;
						end
					end else if (split_idx >= NUM32) begin
						res_status_q <= STATUS_NO_SPACE;
						state_q      <= ST_OUT;
					end else begin
						need_q  <= NW'(split_idx) + NW'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: state_q <= ST_SCAN_CHK;
				ST_SCAN_CHK: begin
					if (rd_data_q == MARK_FREE && run_q + NW'(1) == need_q) begin
						start_q <= scan_start;
						k_q     <= '0;
						state_q <= ST_MARK;
					end else begin
						run_q <= (rd_data_q == MARK_FREE) ? run_q + NW'(1) : '0;
						if (cur_q == LAST_IDX) begin
							res_status_q <= STATUS_NO_SPACE;
							state_q      <= ST_OUT;
						end else begin
							cur_q   <= cur_q + IDX_W'(1);
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_MARK: begin
					// every marked entry was free
					free_cnt_q <= free_cnt_q - CNT_W'(1);
					prod_q     <= PROD_W'(start_q) * PROD_W'(CLUSTER_BYTES);
					if (k_nw + NW'(1) == need_q) begin
						res_status_q <= STATUS_OK;
						state_q      <= ST_OUT;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_F_RD: state_q <= ST_F_CHK;
				ST_F_CHK: begin
					if (k_q == '0) begin
						if (rd_data_q == MARK_SINGLE) begin
							free_cnt_q   <= free_cnt_q + CNT_W'(1);
							res_status_q <= STATUS_FREED;
							state_q      <= ST_OUT;
						end else if (head_fits &&
							(rd_data_q == MARK_FE || rd_data_q == MARK_BB)) begin
							head_q[0] <= rd_data_q;
							k_q       <= IDX_W'(1);
							state_q   <= ST_F_RD;
						end else begin
							res_status_q <= STATUS_IGNORED;
							state_q      <= ST_OUT;
						end
					end else begin
						head_q[k_q[1:0]] <= rd_data_q;
						if (k_q == IDX_W'(3)) begin
							state_q <= ST_F_DEC;
						end else begin
							k_q     <= k_q + IDX_W'(1);
							state_q <= ST_F_RD;
						end
					end
				end
				ST_F_DEC: begin
					if (head_q == HEAD_FOUR) begin
						k_q     <= '0;
						state_q <= ST_CLR4;
					end else if (head_q == HEAD_BIG) begin
						cur_q   <= start_q;
						state_q <= ST_BIG_RD;
					end else begin
						res_status_q <= STATUS_IGNORED;
						state_q      <= ST_OUT;
					end
				end
				ST_CLR4: begin
					free_cnt_q <= free_cnt_q + CNT_W'(1);
					if (k_q == IDX_W'(3)) begin
						res_status_q <= STATUS_FREED;
						state_q      <= ST_OUT;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_BIG_RD: state_q <= ST_BIG_CHK;
				ST_BIG_CHK: begin
					// a CC may close the block; look at the next entry first
					if (cc_pair) begin
						state_q <= ST_BIG_NXT;
					end else begin
						free_cnt_q <= free_cnt_q + CNT_W'(rd_data_q != MARK_FREE);
						if (cur_q == LAST_IDX) begin
							res_status_q <= STATUS_FREED;
							state_q      <= ST_OUT;
						end else begin
							cur_q   <= cur_q + IDX_W'(1);
							state_q <= ST_BIG_RD;
						end
					end
				end
				ST_BIG_NXT: begin
					free_cnt_q <= free_cnt_q + CNT_W'(1);
					cur_q      <= cur_q + IDX_W'(1);
					state_q    <= (rd_data_q == MARK_BB) ? ST_BIG_END : ST_BIG_RD;
				end
				ST_BIG_END: begin
					free_cnt_q   <= free_cnt_q + CNT_W'(1);
					res_status_q <= STATUS_FREED;
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_addr_q   <= (res_status_q == STATUS_OK) ? base_q + ADDR_W'(prod_q) : '0;
			out_free_q   <= FREE_W'(free_cnt_q);
		end
	end

	// Checks
	a_req_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("request taken but sequencer stayed idle");

	a_entry0_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != ST_CLR) |-> mem_waddr != '0)
		else $error("reserved map entry overwritten");

	a_free_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CNT_W'(NUM_CLUSTERS - 1))
		else $error("free entry count out of range");

	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STATUS_OK) |-> m_tdata[ADDR_W-1:0] == '0)
		else $error("block address given for a failed request");

endmodule

>>> tb/cluster_map_allocator_core_tb.sv
// Self-checking testbench for cluster_map_allocator_core: directed table, then random
// allocate/free traffic over several base addresses, idle patterns and stall patterns.
// Depends on cma_pkg and cluster_map_allocator_core.
module cluster_map_allocator_core_tb;
	import cma_pkg::*;

	localparam int NUM         = CMA_NUM_CLUSTERS;
	localparam int CB          = CMA_CLUSTER_BYTES;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int PHASE_ITEMS = 66;

	// One result as the block reports it
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   block_addr;
		logic [FREE_W-1:0]   free_cnt;
	} alloc_result_t;

	typedef struct packed {
		logic          kind;
		logic [31:0]   size;
		logic [31:0]   addr;
		logic          typed;
		alloc_result_t want;
	} directed_row_t;

	localparam alloc_result_t UNTYPED = '0;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic [S_USER_W-1:0] s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [ADDR_W-1:0]   cfg_data  = '0;

	// Predictor state: map image, base address, results still owed
	logic [7:0]    map_image [NUM];
	logic [31:0]   base_addr_model;
	alloc_result_t pending_results [$];
	int unsigned   live_blocks [$];
	int unsigned   idle_pct  = 0;
	int unsigned   stall_pct = 0;
	int unsigned   mismatches = 0;

	// Directed requests; base address is zero throughout
	directed_row_t directed_rows [25] = '{
		'{REQ_ALLOC, 32'd0,        32'h0,        1'b1, '{STATUS_OK, 32'h4000, 10'd1022}},
		'{REQ_ALLOC, 32'd16384,    32'h0,        1'b1, '{STATUS_OK, 32'h8000, 10'd1021}},
		'{REQ_ALLOC, 32'd16385,    32'h0,        1'b0, UNTYPED},
		'{REQ_ALLOC, 32'd65536,    32'h0,        1'b0, UNTYPED},
		'{REQ_ALLOC, 32'd65537,    32'h0,        1'b0, UNTYPED},   // five-entry block
		'{REQ_ALLOC, 32'd5242880,  32'h0,        1'b0, UNTYPED},   // largest block
		'{REQ_ALLOC, 32'd5242881,  32'h0,        1'b1, '{STATUS_TOO_LARGE, 32'h0, 10'd687}},
		'{REQ_ALLOC, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{STATUS_TOO_LARGE, 32'h0, 10'd687}},
		'{REQ_FREE,  32'h0,        32'h2C000,    1'b0, UNTYPED},   // five-entry block not known
		'{REQ_FREE,  32'h0,        32'h4001,     1'b1, '{STATUS_IGNORED, 32'h0, 10'd687}},
		'{REQ_FREE,  32'h0,        32'h1000000,  1'b1, '{STATUS_IGNORED, 32'h0, 10'd687}},
		'{REQ_FREE,  32'h0,        32'h0,        1'b1, '{STATUS_IGNORED, 32'h0, 10'd687}},
		'{REQ_FREE,  32'h0,        32'h10000,    1'b0, UNTYPED},   // inside a four-entry block
		'{REQ_FREE,  32'h0,        32'h4000,     1'b0, UNTYPED},
		'{REQ_FREE,  32'h0,        32'h4000,     1'b0, UNTYPED},   // already free
		'{REQ_FREE,  32'h0,        32'hC000,     1'b0, UNTYPED},
		'{REQ_FREE,  32'h0,        32'h40000,    1'b0, UNTYPED},
		'{REQ_ALLOC, 32'd5242880,  32'h0,        1'b0, UNTYPED},
		'{REQ_ALLOC, 32'd5242880,  32'h0,        1'b0, UNTYPED},
		'{REQ_ALLOC, 32'd5242880,  32'h0,        1'b0, UNTYPED},
		'{REQ_ALLOC, 32'd5242880,  32'h0,        1'b0, UNTYPED},   // no free run long enough
		'{REQ_ALLOC, 32'd720896,   32'h0,        1'b0, UNTYPED},   // run up to the last entry
		'{REQ_ALLOC, 32'd720896,   32'h0,        1'b0, UNTYPED},
		'{REQ_FREE,  32'h0,        32'hF4C000,   1'b0, UNTYPED},   // end mark in the last entries
		'{REQ_FREE,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, UNTYPED}
	};

	cluster_map_allocator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // alloc_size[31:0], free_address[63:32]
		.s_tuser   (s_tuser),   // req_type[0]
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // block_address[31:0], free_entries[41:32], zero
		.m_tuser   (m_tuser),   // status[2:0]
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Map helpers
	function automatic bit run_is_free(int unsigned start, int unsigned len);
		int unsigned k;
		if (start + len > NUM)
			return 1'b0;
		for (k = 0; k < len; k++)
			if (map_image[start + k] != MARK_FREE)
				return 1'b0;
		return 1'b1;
	endfunction

	// Head bytes compared with the first entry in the low byte
	function automatic bit head_is(int unsigned idx, logic [31:0] head);
		if (idx + 4 > NUM)
			return 1'b0;
		return {map_image[idx + 3], map_image[idx + 2], map_image[idx + 1], map_image[idx]} == head;
	endfunction

	// Apply one request to the map image and return the result the block owes
	function automatic alloc_result_t apply_to_map(logic kind, logic [31:0] size,
			logic [31:0] faddr);
		alloc_result_t r;
		int unsigned   need;
		int unsigned   i;
		int unsigned   k;
		int unsigned   idx;
		int unsigned   cnt;
		logic [31:0]   offset;
		bit            placed;
		r      = '0;
		placed = 1'b0;
		if (kind == REQ_ALLOC) begin
			if (size <= CB)
				need = 1;
			else if (size <= 4 * CB)
				need = 4;
			else if (size <= BIG_LIMIT)
				need = size / CB + 1;
			else
				need = 0;
			if (need == 0) begin
				r.status = STATUS_TOO_LARGE;
			end else begin
				r.status = STATUS_NO_SPACE;
				for (i = 1; i < NUM; i++) begin
					if (!placed && run_is_free(i, need)) begin
						placed = 1'b1;
						if (need == 1) begin
							map_image[i] = MARK_SINGLE;
						end else if (need == 4) begin
							map_image[i]     = MARK_FE;
							map_image[i + 1] = MARK_DC;
							map_image[i + 2] = MARK_BA;
							map_image[i + 3] = MARK_B8;
						end else begin
							for (k = 0; k < need; k++)
								map_image[i + k] = MARK_FILL;
							map_image[i]            = MARK_BB;
							map_image[i + 1]        = MARK_CC;
							map_image[i + need - 2] = MARK_CC;
							map_image[i + need - 1] = MARK_BB;
						end
						r.status     = STATUS_OK;
						r.block_addr = base_addr_model + i * CB;
						live_blocks.push_back(i);
					end
				end
			end
		end else begin
			r.status = STATUS_IGNORED;
			offset   = faddr - base_addr_model;
			if (offset % CB == 0 && offset / CB < NUM) begin
				idx = offset / CB;
				if (map_image[idx] == MARK_SINGLE) begin
					map_image[idx] = MARK_FREE;
					r.status = STATUS_FREED;
				end else if (head_is(idx, HEAD_FOUR)) begin
					for (k = 0; k < 4; k++)
						map_image[idx + k] = MARK_FREE;
					r.status = STATUS_FREED;
				end else if (head_is(idx, HEAD_BIG)) begin
					// clear up to and including the first CC BB pair, or to the map end
					for (k = idx; k < NUM && !placed; k++) begin
						if (map_image[k] == MARK_CC && k + 1 < NUM &&
								map_image[k + 1] == MARK_BB) begin
							map_image[k + 1] = MARK_FREE;
							placed = 1'b1;
						end
						map_image[k] = MARK_FREE;
					end
					r.status = STATUS_FREED;
				end
			end
		end
		cnt = 0;
		for (i = 0; i < NUM; i++)
			if (map_image[i] == MARK_FREE)
				cnt++;
		r.free_cnt = cnt[FREE_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
	endtask

	// Offer one request; called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(logic kind, logic [31:0] size, logic [31:0] addr,
			logic typed, alloc_result_t want);
		alloc_result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {addr, size};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_to_map(kind, size, addr);
		pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Drain all results, then write the base address register
	task automatic write_base(logic [31:0] value);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		base_addr_model = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly frees of live blocks and allocations of mixed sizes, some noise frees
	task automatic random_request(output logic kind, output logic [31:0] size,
			output logic [31:0] addr);
		int unsigned pick;
		int unsigned slot;
		pick = $urandom_range(99);
		size = $urandom;
		addr = $urandom;
		if (live_blocks.size() != 0 && pick < 45) begin
			kind = REQ_FREE;
			slot = $urandom_range(live_blocks.size() - 1);
			addr = base_addr_model + live_blocks[slot] * CB;
			live_blocks.delete(slot);
		end else if (pick < 55) begin
			kind = REQ_FREE;
			if ($urandom_range(1))
				addr = base_addr_model + $urandom_range(NUM + 3) * CB +
					($urandom_range(3) == 0 ? $urandom_range(CB - 1) : 0);
		end else begin
			kind = REQ_ALLOC;
			pick = $urandom_range(99);
			if (pick < 30)
				size = $urandom_range(CB);
			else if (pick < 55)
				size = $urandom_range(4 * CB, CB + 1);
			else if (pick < 85)
				size = $urandom_range(16 * CB, 4 * CB + 1);
			else if (pick < 92)
				size = $urandom_range(BIG_LIMIT, 16 * CB + 1);
			else
				size = $urandom_range(32'hFFFFFFFF, BIG_LIMIT + 1);
		end
	endtask

	// Result ready with random stalls
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// Compare every accepted result with the oldest one owed
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser[STATUS_W-1:0] != want.status)
					report_mismatch("status", 32'(m_tuser[STATUS_W-1:0]),
						32'(want.status));
				if (m_tdata[31:0] != want.block_addr)
					report_mismatch("block address", m_tdata[31:0], want.block_addr);
				if (m_tdata[41:32] != want.free_cnt)
					report_mismatch("free entries", 32'(m_tdata[41:32]),
						32'(want.free_cnt));
			end
		end
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** cluster_map_allocator_core: FAILED **");
		$finish;
	end

	initial begin
		int unsigned   row;
		int unsigned   ph;
		int unsigned   n;
		logic          kind;
		logic [31:0]   size;
		logic [31:0]   addr;
		logic [31:0]   phase_base [4];
		int unsigned   phase_idle [4];
		int unsigned   phase_stall [4];
		phase_base  = '{32'hFFFFFFFF, $urandom, 32'hFFFFC000, 32'h0};
		phase_idle  = '{0, 74, 0, 36};
		phase_stall = '{0, 0, 74, 36};

		// Reset state of the predictor
		for (n = 0; n < NUM; n++)
			map_image[n] = MARK_FREE;
		map_image[0]    = MARK_FILL;
		base_addr_model = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table
		for (row = 0; row < 25; row++)
			send_request(directed_rows[row].kind, directed_rows[row].size,
				directed_rows[row].addr, directed_rows[row].typed, directed_rows[row].want);

		// Random traffic, one base address, idle pattern and stall pattern per phase
		for (ph = 0; ph < 4; ph++) begin
			write_base(phase_base[ph]);
			idle_pct  = phase_idle[ph];
			stall_pct = phase_stall[ph];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				random_request(kind, size, addr);
				send_request(kind, size, addr, 1'b0, UNTYPED);
			end
		end
		s_tvalid <= 1'b0;

		// Drain, then watch for stray results
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * NUM + 64) @(posedge clk);

		if (mismatches == 0)
			$display("** cluster_map_allocator_core: PASSED **");
		else
			$display("** cluster_map_allocator_core: FAILED **");
		$finish;
	end

endmodule

>>> cluster_map_allocator_core.f
sv/cma_pkg.sv
sv/cluster_map_allocator_core.sv
tb/cluster_map_allocator_core_tb.sv
